@@ hdl/fsa_pkg.sv @@
package fsa_pkg;

  localparam int ACC_W     = 32;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;
  localparam int PROD_W    = ACC_W + IN_W;
  localparam int MUL_CNT_W = $clog2(IN_W);
  localparam int DIV_CNT_W = $clog2(ACC_W);
  localparam int SHIFT_W   = $clog2(ACC_W);
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_OP_MODE = 1'b0;

  // Multiply steps of one fold
  localparam logic [1:0] STEP_A = 2'd0;
  localparam logic [1:0] STEP_B = 2'd1;
  localparam logic [1:0] STEP_C = 2'd2;

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_DIFF = 2'd1,
    MODE_PROD = 2'd2,
    MODE_QUO  = 2'd3
  } op_mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVF      = 2'd2,
    STATUS_BAD_IN   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_FOLD,
    ST_RSTART,
    ST_REDUCE,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_GCD,
    RED_DIV,
    RED_DONE
  } red_state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] a;
    logic [IN_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [ACC_W-1:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] den;
  } red_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] den;
  } red_rsp_t;

endpackage

@@ hdl/fsa_mul.sv @@
// Serial signed multiplier: one multiplier bit per cycle, MSB first,
// on magnitudes, with the sign and overflow resolved at the end.
module fsa_mul (
  input  logic              clk,
  input  logic              rst,
  input  fsa_pkg::mul_req_t req,
  output fsa_pkg::mul_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [fsa_pkg::MUL_CNT_W-1:0]  count;
  logic [fsa_pkg::ACC_W-1:0]      mcand;
  logic [fsa_pkg::IN_W-1:0]       mult;
  logic [fsa_pkg::PROD_W-1:0]     prod;
  logic [fsa_pkg::PROD_W-1:0]     prod_next;
  logic                           neg;
  logic [fsa_pkg::ACC_W-1:0]      mag_a;
  logic [fsa_pkg::IN_W-1:0]       mag_b;
  logic [fsa_pkg::ACC_W-1:0]      low;

  assign mag_a = req.a[fsa_pkg::ACC_W-1] ? (~req.a + 1'b1) : req.a;
  assign mag_b = req.b[fsa_pkg::IN_W-1]  ? (~req.b + 1'b1) : req.b;

  assign prod_next = {prod[fsa_pkg::PROD_W-2:0], 1'b0}
                   + (mult[fsa_pkg::IN_W-1] ? {{fsa_pkg::IN_W{1'b0}}, mcand}
                                            : {fsa_pkg::PROD_W{1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == fsa_pkg::MUL_CNT_W'(fsa_pkg::IN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= mag_a;
      mult  <= mag_b;
      prod  <= '0;
      neg   <= req.a[fsa_pkg::ACC_W-1] ^ req.b[fsa_pkg::IN_W-1];
    end else if (busy) begin
      prod <= prod_next;
      mult <= {mult[fsa_pkg::IN_W-2:0], 1'b0};
    end
  end

  assign low = prod[fsa_pkg::ACC_W-1:0];

  always_comb begin
    rsp.done  = done;
    rsp.value = neg ? (~low + 1'b1) : low;
    // out of range above 2^(W-1), or exactly 2^(W-1) when positive
    rsp.ovf   = (|prod[fsa_pkg::PROD_W-1:fsa_pkg::ACC_W])
             || (prod[fsa_pkg::ACC_W-1] && ((|prod[fsa_pkg::ACC_W-2:0]) || !neg));
  end

endmodule

@@ hdl/fsa_reduce.sv @@
// Reduce a fraction by the GCD of its magnitudes: binary GCD one step a
// cycle, then two restoring dividers one quotient bit a cycle.
module fsa_reduce (
  input  logic              clk,
  input  logic              rst,
  input  fsa_pkg::red_req_t req,
  output fsa_pkg::red_rsp_t rsp
);

  fsa_pkg::red_state_t state;
  fsa_pkg::red_state_t state_next;

  logic [fsa_pkg::ACC_W-1:0]     u;
  logic [fsa_pkg::ACC_W-1:0]     v;
  logic [fsa_pkg::ACC_W-1:0]     g;
  logic [fsa_pkg::SHIFT_W-1:0]   shift;
  logic [fsa_pkg::ACC_W-1:0]     xn;
  logic [fsa_pkg::ACC_W-1:0]     xd;
  logic [fsa_pkg::ACC_W-1:0]     rem_n;
  logic [fsa_pkg::ACC_W-1:0]     rem_d;
  logic [fsa_pkg::DIV_CNT_W-1:0] count;
  logic                          neg_n;
  logic                          neg_d;

  logic                          gcd_end;
  logic                          g_zero;
  logic                          div_end;
  logic [fsa_pkg::ACC_W:0]       rsh_n;
  logic [fsa_pkg::ACC_W:0]       rsh_d;
  logic                          ge_n;
  logic                          ge_d;

  assign gcd_end = (u == '0) || (v == '0);
  assign g_zero  = (u | v) == '0;
  assign div_end = count == fsa_pkg::DIV_CNT_W'(fsa_pkg::ACC_W - 1);

  assign rsh_n = {rem_n, xn[fsa_pkg::ACC_W-1]};
  assign rsh_d = {rem_d, xd[fsa_pkg::ACC_W-1]};
  assign ge_n  = rsh_n >= {1'b0, g};
  assign ge_d  = rsh_d >= {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsa_pkg::RED_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fsa_pkg::RED_IDLE: begin
        if (req.start) state_next = fsa_pkg::RED_GCD;
      end
      fsa_pkg::RED_GCD: begin
        if (gcd_end) state_next = g_zero ? fsa_pkg::RED_DONE : fsa_pkg::RED_DIV;
      end
      fsa_pkg::RED_DIV: begin
        if (div_end) state_next = fsa_pkg::RED_DONE;
      end
      fsa_pkg::RED_DONE: state_next = fsa_pkg::RED_IDLE;
      default:           state_next = fsa_pkg::RED_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = state == fsa_pkg::RED_DONE;
    rsp.num  = neg_n ? (~xn + 1'b1) : xn;
    rsp.den  = neg_d ? (~xd + 1'b1) : xd;
  end

  always_ff @(posedge clk) begin
    if (state == fsa_pkg::RED_IDLE && req.start) begin
      neg_n <= req.num[fsa_pkg::ACC_W-1];
      neg_d <= req.den[fsa_pkg::ACC_W-1];
      xn    <= req.num[fsa_pkg::ACC_W-1] ? (~req.num + 1'b1) : req.num;
      xd    <= req.den[fsa_pkg::ACC_W-1] ? (~req.den + 1'b1) : req.den;
      u     <= req.num[fsa_pkg::ACC_W-1] ? (~req.num + 1'b1) : req.num;
      v     <= req.den[fsa_pkg::ACC_W-1] ? (~req.den + 1'b1) : req.den;
      shift <= '0;
    end else if (state == fsa_pkg::RED_GCD) begin
      if (gcd_end) begin
        // odd part of the GCD; the common power of two comes off the dividends
        g     <= u | v;
        xn    <= xn >> shift;
        xd    <= xd >> shift;
        rem_n <= '0;
        rem_d <= '0;
        count <= '0;
      end else if (!u[0] && !v[0]) begin
        u     <= u >> 1;
        v     <= v >> 1;
        shift <= shift + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end else if (state == fsa_pkg::RED_DIV) begin
      rem_n <= ge_n ? fsa_pkg::ACC_W'(rsh_n - {1'b0, g}) : rsh_n[fsa_pkg::ACC_W-1:0];
      rem_d <= ge_d ? fsa_pkg::ACC_W'(rsh_d - {1'b0, g}) : rsh_d[fsa_pkg::ACC_W-1:0];
      xn    <= {xn[fsa_pkg::ACC_W-2:0], ge_n};
      xd    <= {xd[fsa_pkg::ACC_W-2:0], ge_d};
      count <= count + 1'b1;
    end
  end

endmodule

@@ hdl/fraction_sequence_accumulator_unit.sv @@
// Folds a sequence of fractions by sum, difference, product or quotient (op_mode)
// and emits one GCD-reduced fraction with a status code when the word marked last
// has been taken. The first word of a sequence loads the accumulator directly.
// Each later word runs through a single serial multiplier that retires one bit of the
// 16-bit input operand per cycle: three products per word in sum or difference mode
// and two in product or quotient mode. After the last word the reduction takes one
// binary GCD step per cycle and then divides the numerator and denominator by the
// GCD. The result waits in an output register; the input is stalled from acceptance
// until the accumulator is free again. The result's sign is left as computed.
module fraction_sequence_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fsa_pkg::IN_W-1:0]     numerator,
  input  logic signed [fsa_pkg::IN_W-1:0]     denominator,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fsa_pkg::OUT_W-1:0]    result_numerator,
  output logic signed [fsa_pkg::OUT_W-1:0]    result_denominator,
  output logic [1:0]                          status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fsa_pkg::PADDR_W-1:0]         paddr,
  input  logic [fsa_pkg::PDATA_W-1:0]         pwdata,
  output logic [fsa_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  fsa_pkg::top_state_t state;
  fsa_pkg::top_state_t state_next;
  fsa_pkg::op_mode_t   op_mode;

  logic [fsa_pkg::ACC_W-1:0] acc_n;
  logic [fsa_pkg::ACC_W-1:0] acc_d;
  logic                      started;
  logic                      ovf_seen;
  logic                      bad_seen;
  logic [fsa_pkg::IN_W-1:0]  n_in;
  logic [fsa_pkg::IN_W-1:0]  d_in;
  logic                      last_in;
  logic [1:0]                step;
  logic [fsa_pkg::ACC_W-1:0] r0;
  logic [fsa_pkg::ACC_W-1:0] r1;
  logic [fsa_pkg::ACC_W-1:0] r2;

  fsa_pkg::mul_req_t mul_req;
  fsa_pkg::mul_rsp_t mul_rsp;
  fsa_pkg::red_req_t red_req;
  fsa_pkg::red_rsp_t red_rsp;

  logic                      accept;
  logic                      out_free;
  logic                      emit;
  logic                      addsub;
  logic                      last_step;
  logic                      sub;
  logic [fsa_pkg::ACC_W-1:0] sum;
  logic                      sum_ovf;
  logic                      sb;
  fsa_pkg::status_t          status_next;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fsa_pkg::REG_OP_MODE)
                ? {{(fsa_pkg::PDATA_W - 2){1'b0}}, op_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= fsa_pkg::MODE_SUM;
    end else if (psel && penable && pwrite && pready && paddr[2] == fsa_pkg::REG_OP_MODE) begin
      op_mode <= fsa_pkg::op_mode_t'(pwdata[1:0]);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign addsub   = op_mode == fsa_pkg::MODE_SUM || op_mode == fsa_pkg::MODE_DIFF;
  assign last_step = addsub ? (step == fsa_pkg::STEP_C) : (step == fsa_pkg::STEP_B);

  // State register and next state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (started)   state_next = fsa_pkg::ST_ISSUE;
          else if (last) state_next = fsa_pkg::ST_RSTART;
        end
      end
      fsa_pkg::ST_ISSUE: state_next = fsa_pkg::ST_MUL;
      fsa_pkg::ST_MUL: begin
        if (mul_rsp.done) state_next = last_step ? fsa_pkg::ST_FOLD : fsa_pkg::ST_ISSUE;
      end
      fsa_pkg::ST_FOLD:   state_next = last_in ? fsa_pkg::ST_RSTART : fsa_pkg::ST_IDLE;
      fsa_pkg::ST_RSTART: state_next = fsa_pkg::ST_REDUCE;
      fsa_pkg::ST_REDUCE: begin
        if (red_rsp.done) state_next = fsa_pkg::ST_EMIT;
      end
      fsa_pkg::ST_EMIT: begin
        if (out_free) state_next = fsa_pkg::ST_IDLE;
      end
      default: state_next = fsa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall      = state != fsa_pkg::ST_IDLE;
    emit          = state == fsa_pkg::ST_EMIT && out_free;
  end

  // Operand selection for the current multiply step
  always_comb begin
    mul_req.start = state == fsa_pkg::ST_ISSUE;
    mul_req.a = acc_n;
    mul_req.b = d_in;
    case (op_mode)
      fsa_pkg::MODE_SUM, fsa_pkg::MODE_DIFF: begin
        case (step)
          fsa_pkg::STEP_A: begin mul_req.a = acc_n; mul_req.b = d_in; end
          fsa_pkg::STEP_B: begin mul_req.a = acc_d; mul_req.b = n_in; end
          default:         begin mul_req.a = acc_d; mul_req.b = d_in; end
        endcase
      end
      fsa_pkg::MODE_PROD: begin
        mul_req.a = (step == fsa_pkg::STEP_A) ? acc_n : acc_d;
        mul_req.b = (step == fsa_pkg::STEP_A) ? n_in  : d_in;
      end
      default: begin
        mul_req.a = (step == fsa_pkg::STEP_A) ? acc_n : acc_d;
        mul_req.b = (step == fsa_pkg::STEP_A) ? d_in  : n_in;
      end
    endcase
  end

  assign red_req.start = state == fsa_pkg::ST_RSTART;
  assign red_req.num   = acc_n;
  assign red_req.den   = acc_d;

  fsa_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  fsa_reduce u_reduce (
    .clk (clk),
    .rst (rst),
    .req (red_req),
    .rsp (red_rsp)
  );

  // Cross-product add or subtract with signed overflow
  assign sub     = op_mode == fsa_pkg::MODE_DIFF;
  assign sum     = sub ? (r0 - r1) : (r0 + r1);
  assign sb      = sub ? !r1[fsa_pkg::ACC_W-1] : r1[fsa_pkg::ACC_W-1];
  assign sum_ovf = (r0[fsa_pkg::ACC_W-1] == sb)
                && (sum[fsa_pkg::ACC_W-1] != r0[fsa_pkg::ACC_W-1]);

  always_comb begin
    if (bad_seen)       status_next = fsa_pkg::STATUS_BAD_IN;
    else if (ovf_seen)  status_next = fsa_pkg::STATUS_OVF;
    else if (op_mode == fsa_pkg::MODE_QUO && red_rsp.den == '0)
                        status_next = fsa_pkg::STATUS_ZERO_DEN;
    else                status_next = fsa_pkg::STATUS_OK;
  end

  // Accumulator and sequence flags
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_n    <= '0;
      acc_d    <= fsa_pkg::ACC_W'(1);
      started  <= 1'b0;
      ovf_seen <= 1'b0;
      bad_seen <= 1'b0;
      step     <= fsa_pkg::STEP_A;
    end else begin
      if (accept) begin
        step <= fsa_pkg::STEP_A;
        if (denominator == '0) bad_seen <= 1'b1;
        if (!started) begin
          acc_n   <= {{(fsa_pkg::ACC_W - fsa_pkg::IN_W){numerator[fsa_pkg::IN_W-1]}},
                      numerator};
          acc_d   <= {{(fsa_pkg::ACC_W - fsa_pkg::IN_W){denominator[fsa_pkg::IN_W-1]}},
                      denominator};
          started <= 1'b1;
        end
      end
      if (state == fsa_pkg::ST_MUL && mul_rsp.done) begin
        step <= step + 1'b1;
        if (mul_rsp.ovf) ovf_seen <= 1'b1;
      end
      if (state == fsa_pkg::ST_FOLD) begin
        if (addsub) begin
          acc_n <= sum;
          acc_d <= r2;
          if (sum_ovf) ovf_seen <= 1'b1;
        end else begin
          acc_n <= r0;
          acc_d <= r1;
        end
      end
      if (emit) begin
        // clear for the next sequence
        acc_n    <= '0;
        acc_d    <= fsa_pkg::ACC_W'(1);
        started  <= 1'b0;
        ovf_seen <= 1'b0;
        bad_seen <= 1'b0;
      end
    end
  end

  // Held input word and product results
  always_ff @(posedge clk) begin
    if (accept) begin
      n_in    <= numerator;
      d_in    <= denominator;
      last_in <= last;
    end
    if (state == fsa_pkg::ST_MUL && mul_rsp.done) begin
      case (step)
        fsa_pkg::STEP_A: r0 <= mul_rsp.value;
        fsa_pkg::STEP_B: r1 <= mul_rsp.value;
        default:         r2 <= mul_rsp.value;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_numerator   <= red_rsp.num[fsa_pkg::OUT_W-1:0];
      result_denominator <= red_rsp.den[fsa_pkg::OUT_W-1:0];
      status             <= status_next;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == fsa_pkg::ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  assert property (@(posedge clk) disable iff (rst)
    red_rsp.done |-> state == fsa_pkg::ST_REDUCE)
    else $error("reduction finished outside the reduce phase");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !started && !last) |=> (state == fsa_pkg::ST_IDLE && started))
    else $error("first word of a sequence did not load the accumulator");

  assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && !started && !ovf_seen && !bad_seen))
    else $error("result emitted without clearing the sequence state");

endmodule
